### src/generational_handle_pool_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the generational handle pool
// Immediate-implication and next-cycle forms, clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_POOL_ASSERT_SVH
`define GENERATIONAL_HANDLE_POOL_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define GHP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error("ghpool assertion failed");
`define GHP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error("ghpool assertion failed");
`else
`define GHP_ASSERT_IMP(lbl, ante, cons)
`define GHP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### src/ghpool_pkg.sv
// ----------------------------------------------------------------------------
// ghpool_pkg
// Shared types, request and status codes and defaults for the handle pool.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ghpool_pkg;

    localparam int P_POOL_SIZE   = 256;
    localparam int P_GROUP_COUNT = 5;
    localparam int GROUP_SLOTS   = 8;

    localparam logic [15:0] NO_GEN = 16'hFFFF;

    localparam logic [2:0] REQ_ALLOC      = 3'd0;
    localparam logic [2:0] REQ_LOAD       = 3'd1;
    localparam logic [2:0] REQ_UNLOAD     = 3'd2;
    localparam logic [2:0] REQ_USE        = 3'd3;
    localparam logic [2:0] REQ_GROUP_INIT = 3'd4;
    localparam logic [2:0] REQ_GROUP_USE  = 3'd5;

    localparam logic [3:0] ST_OK            = 4'd0;
    localparam logic [3:0] ST_EXHAUSTED     = 4'd1;
    localparam logic [3:0] ST_INDEX         = 4'd2;
    localparam logic [3:0] ST_STALE         = 4'd3;
    localparam logic [3:0] ST_NOT_LOADED    = 4'd4;
    localparam logic [3:0] ST_SOURCE        = 4'd5;
    localparam logic [3:0] ST_USAGE         = 4'd6;
    localparam logic [3:0] ST_GROUP_RANGE   = 4'd7;
    localparam logic [3:0] ST_GROUP_UNINIT  = 4'd8;
    localparam logic [3:0] ST_GROUP_ALREADY = 4'd9;
    localparam logic [3:0] ST_OVERFLOW      = 4'd10;

    localparam int          CFG_IDX_W        = 1;
    localparam int          CFG_DATA_W       = 8;
    localparam logic [0:0]  CFG_SOURCE_COUNT = 1'd0;
    localparam logic [0:0]  CFG_USAGE_COUNT  = 1'd1;
    localparam logic [7:0]  SOURCE_COUNT_RST = 8'd2;
    localparam logic [3:0]  USAGE_COUNT_RST  = 4'd3;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] handle_index;
        logic [15:0] handle_gen;
        logic [7:0]  source_id;
        logic [7:0]  group_id;
        logic [3:0]  usage_kind;
    } t_req;

    typedef struct packed {
        logic [3:0]  status;
        logic [7:0]  out_index;
        logic [15:0] out_gen;
        logic        was_reloaded;
    } t_rsp;

    typedef struct packed {
        logic latch;
        logic chase;
        logic eval;
    } t_dp_cmd;

    typedef struct packed {
        logic known;
        logic alloc;
    } t_dp_stat;

endpackage

### src/ghpool_ram.sv
// ----------------------------------------------------------------------------
// ghpool_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ghpool_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/ghpool_ctrl.sv
// ----------------------------------------------------------------------------
// ghpool_ctrl
// Request sequencer: latch, memory read, optional stack chase, evaluate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "generational_handle_pool_assert.svh"

module ghpool_ctrl
    import ghpool_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_STK   = 2'd2;
    localparam logic [1:0] S_EVAL  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (!i_stat.known) begin
                    n_state = S_IDLE;
                end else if (i_stat.alloc) begin
                    n_state = S_STK;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_STK:   n_state = S_EVAL;
            S_EVAL:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cmd.latch = start && (r_state == S_IDLE);
    assign o_cmd.chase = (r_state == S_STK);
    assign o_cmd.eval  = (r_state == S_EVAL);

    `GHP_ASSERT_NXT(a_accept_issue, start && !busy, r_state == S_ISSUE)
    `GHP_ASSERT_NXT(a_eval_done, r_state == S_EVAL, r_state == S_IDLE)
    `GHP_ASSERT_IMP(a_stk_after_issue, r_state == S_STK, $past(r_state) == S_ISSUE)

endmodule

### src/ghpool_dp.sv
// ----------------------------------------------------------------------------
// ghpool_dp
// Datapath: free stack, generation/loaded store, group flags, config
// registers, handle checks and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "generational_handle_pool_assert.svh"

module ghpool_dp
    import ghpool_pkg::*;
#(
    parameter int POOL_SIZE   = P_POOL_SIZE,
    parameter int GROUP_COUNT = P_GROUP_COUNT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_req                  i_req,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_valid,
    output t_rsp                  o_rsp
);

    localparam int AW = $clog2(POOL_SIZE);
    localparam int CW = $clog2(POOL_SIZE + 1);
    localparam logic [15:0] IDX_LIM = 16'(POOL_SIZE);
    localparam logic [CW-1:0] CNT_FULL = CW'(POOL_SIZE);
    localparam logic [7:0] GRP_LIM = 8'(GROUP_COUNT);

    t_req                   r_req;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_low, n_low;
    logic [GROUP_SLOTS-1:0] r_grp_rdy, n_grp_rdy;
    logic [7:0]             r_src_cnt;
    logic [3:0]             r_use_cnt;
    logic [POOL_SIZE-1:0]   r_gen_vld;
    logic                   r_vld_q;
    logic [7:0]             r_slot;
    logic                   r_valid;
    t_rsp                   r_rsp;

    logic [CW-1:0] pos;
    logic [7:0]    stk_rdata;
    logic [7:0]    stk_val;
    logic          stk_we;
    logic [AW-1:0] gen_raddr;
    logic [16:0]   gen_rdata;
    logic          gen_we;
    logic [16:0]   gen_wdata;
    logic [AW-1:0] gen_waddr;
    logic [15:0]   slot_gen;
    logic          slot_ld;
    logic          idx_ok;
    logic          grp_ok;
    logic          grp_rdy;
    t_rsp          n_rsp;
    logic [15:0]   gen_inc;

    assign o_stat.known = (r_req.req_type <= REQ_GROUP_USE);
    assign o_stat.alloc = (r_req.req_type == REQ_ALLOC);

    // stack top; entries below the low mark were never written
    assign pos     = r_count - CW'(1);
    assign stk_val = (pos >= r_low) ? stk_rdata : 8'(pos);

    assign gen_raddr = i_cmd.chase ? stk_val[AW-1:0] : r_req.handle_index[AW-1:0];
    assign gen_waddr = r_req.handle_index[AW-1:0];

    ghpool_ram #(
        .WIDTH (8),
        .DEPTH (POOL_SIZE)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_req.handle_index[7:0]),
        .i_raddr (pos[AW-1:0]),
        .o_rdata (stk_rdata)
    );

    ghpool_ram #(
        .WIDTH (17),
        .DEPTH (POOL_SIZE)
    ) u_gen (
        .i_clk   (i_clk),
        .i_we    (gen_we),
        .i_waddr (gen_waddr),
        .i_wdata (gen_wdata),
        .i_raddr (gen_raddr),
        .o_rdata (gen_rdata)
    );

    assign slot_gen = r_vld_q ? gen_rdata[15:0] : 16'd0;
    assign slot_ld  = r_vld_q ? gen_rdata[16] : 1'b0;
    assign gen_inc  = slot_gen + 16'd1;
    assign idx_ok   = (r_req.handle_index < IDX_LIM);
    assign grp_ok   = (r_req.group_id < GRP_LIM);
    assign grp_rdy  = r_grp_rdy[r_req.group_id[2:0]];

    always_comb begin
        n_rsp     = '0;
        n_count   = r_count;
        n_low     = r_low;
        n_grp_rdy = r_grp_rdy;
        stk_we    = 1'b0;
        gen_we    = 1'b0;
        gen_wdata = {1'b0, slot_gen};
        case (r_req.req_type)
            REQ_ALLOC: begin
                if (r_count == '0) begin
                    n_rsp.status  = ST_EXHAUSTED;
                    n_rsp.out_gen = NO_GEN;
                end else begin
                    n_count           = pos;
                    n_low             = (pos < r_low) ? pos : r_low;
                    n_rsp.out_index   = r_slot;
                    n_rsp.out_gen     = slot_gen;
                end
            end
            REQ_LOAD: begin
                if (!grp_ok) begin
                    n_rsp.status = ST_GROUP_RANGE;
                end else if (!grp_rdy) begin
                    n_rsp.status = ST_GROUP_UNINIT;
                end else if (r_req.source_id >= r_src_cnt) begin
                    n_rsp.status = ST_SOURCE;
                end else if (r_req.usage_kind >= r_use_cnt) begin
                    n_rsp.status = ST_USAGE;
                end else if (!idx_ok) begin
                    n_rsp.status = ST_INDEX;
                end else if (r_req.handle_gen != slot_gen) begin
                    n_rsp.status = ST_STALE;
                end else begin
                    gen_we             = 1'b1;
                    gen_wdata          = {1'b1, slot_gen};
                    n_rsp.out_index    = r_req.handle_index[7:0];
                    n_rsp.out_gen      = slot_gen;
                    n_rsp.was_reloaded = slot_ld;
                end
            end
            REQ_UNLOAD, REQ_USE: begin
                if (!idx_ok) begin
                    n_rsp.status = ST_INDEX;
                end else if (r_req.handle_gen != slot_gen) begin
                    n_rsp.status = ST_STALE;
                end else if (!slot_ld) begin
                    n_rsp.status = ST_NOT_LOADED;
                end else if (r_req.req_type == REQ_USE) begin
                    n_rsp.out_index = r_req.handle_index[7:0];
                    n_rsp.out_gen   = slot_gen;
                end else begin
                    gen_we    = 1'b1;
                    gen_wdata = {1'b0, gen_inc};
                    if (r_count >= CNT_FULL) begin
                        n_rsp.status = ST_OVERFLOW;
                    end else begin
                        stk_we          = 1'b1;
                        n_count         = r_count + CW'(1);
                        n_rsp.out_index = r_req.handle_index[7:0];
                        n_rsp.out_gen   = gen_inc;
                    end
                end
            end
            REQ_GROUP_INIT: begin
                if (!grp_ok) begin
                    n_rsp.status = ST_GROUP_RANGE;
                end else if (grp_rdy) begin
                    n_rsp.status = ST_GROUP_ALREADY;
                end else begin
                    n_grp_rdy[r_req.group_id[2:0]] = 1'b1;
                end
            end
            REQ_GROUP_USE: begin
                if (!grp_ok) begin
                    n_rsp.status = ST_GROUP_RANGE;
                end else if (!grp_rdy) begin
                    n_rsp.status = ST_GROUP_UNINIT;
                end
            end
            default: begin
                n_rsp = '0;
            end
        endcase
        if (!i_cmd.eval) begin
            stk_we = 1'b0;
            gen_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= i_req;
        end
        if (i_cmd.chase) begin
            r_slot <= stk_val;
        end
        r_vld_q <= r_gen_vld[gen_raddr];
        if (i_cmd.eval) begin
            r_rsp <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= CNT_FULL;
            r_low     <= CNT_FULL;
            r_gen_vld <= '0;
            r_valid   <= 1'b0;
            r_src_cnt <= SOURCE_COUNT_RST;
            r_use_cnt <= USAGE_COUNT_RST;
            for (int g = 0; g < GROUP_SLOTS; g++) begin
                r_grp_rdy[g] <= (g < GROUP_COUNT);
            end
        end else begin
            r_valid <= i_cmd.eval;
            if (i_cmd.eval) begin
                r_count   <= n_count;
                r_low     <= n_low;
                r_grp_rdy <= n_grp_rdy;
            end
            if (gen_we) begin
                r_gen_vld[gen_waddr] <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SOURCE_COUNT: r_src_cnt <= i_cfg_data;
                    CFG_USAGE_COUNT:  r_use_cnt <= i_cfg_data[3:0];
                    default:          r_src_cnt <= r_src_cnt;
                endcase
            end
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    `GHP_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_FULL)
    `GHP_ASSERT_IMP(a_low_mark, 1'b1, r_low <= r_count)
    `GHP_ASSERT_IMP(a_exhausted_empty, r_valid && (r_rsp.status == ST_EXHAUSTED),
                    r_count == '0)

endmodule

### src/generational_handle_pool.sv
// ----------------------------------------------------------------------------
// generational_handle_pool
// Slot pool with per-slot generation counters and a LIFO free stack.
//
// Requests: drive i_req and pulse start while busy is low; the request is
// taken at that edge. One result per known request type appears on o_rsp
// for exactly one cycle with o_valid high; request types 6 and 7 are
// dropped with no result. The receiver cannot stall.
// Allocate passes through issue, stack chase and evaluate, other requests
// through issue and evaluate; busy is high there, so a new request is taken
// only once the last is evaluated. Allocate reads the free stack, then the
// generation store at the popped index. Configuration: i_cfg_we, i_cfg_idx
// (0 source count, 1 usage count) and i_cfg_data write a register at the
// clock edge; the user writes only while the block is idle, not enforced here.
// Reset (synchronous, active low): stack full with entry i holding i, all
// generations zero, nothing loaded, first GROUP_COUNT groups ready,
// source count 2, usage count 3. No clearing pass; ready right after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module generational_handle_pool
    import ghpool_pkg::*;
#(
    parameter int POOL_SIZE   = P_POOL_SIZE,
    parameter int GROUP_COUNT = P_GROUP_COUNT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_req                  i_req,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_valid,
    output t_rsp                  o_rsp
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    ghpool_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    ghpool_dp #(
        .POOL_SIZE   (POOL_SIZE),
        .GROUP_COUNT (GROUP_COUNT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_rsp      (o_rsp)
    );

endmodule

### tb/tb_generational_handle_pool.sv
// ----------------------------------------------------------------------------
// tb_generational_handle_pool
// Self-checking bench for the generational handle pool. Requests go in on the
// start/busy handshake and an in-bench pool tracker (free stack, generations,
// loaded marks, group flags) predicts each response. Responses are checked in
// order, field by field. The run covers directed corner cases, pool
// exhaustion, and random handle lifecycles under several source and usage
// count settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_generational_handle_pool;
    import ghpool_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int PHASE_ITEMS   = 215;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 150000;
    localparam int MAX_REPORTS   = 10;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  start      = 1'b0;
    logic                  busy;
    t_req                  i_req      = '0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_valid;
    t_rsp                  o_rsp;

    // pool tracker
    logic [7:0]  free_slots [P_POOL_SIZE];
    int unsigned free_depth;
    logic [15:0] slot_gen [P_POOL_SIZE];
    bit          slot_loaded [P_POOL_SIZE];
    bit          group_ready [GROUP_SLOTS];
    logic [7:0]  source_limit;
    logic [3:0]  usage_limit;

    t_rsp        awaited_rsp [$];
    logic [7:0]  live_slots [$];
    bit          steady_flow = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned stray_count = 0;
    int unsigned report_count = 0;

    generational_handle_pool i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_rsp      (o_rsp)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, awaited_rsp.size());
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_req make_request(input logic [2:0] kind, input logic [15:0] idx,
                                          input logic [15:0] gen, input logic [7:0] src,
                                          input logic [7:0] grp, input logic [3:0] usage);
        t_req r;
        r.req_type     = kind;
        r.handle_index = idx;
        r.handle_gen   = gen;
        r.source_id    = src;
        r.group_id     = grp;
        r.usage_kind   = usage;
        return r;
    endfunction

    function automatic void reset_pool_tracker();
        for (int i = 0; i < P_POOL_SIZE; i++) begin
            free_slots[i]  = 8'(i);
            slot_gen[i]    = '0;
            slot_loaded[i] = 1'b0;
        end
        free_depth = P_POOL_SIZE;
        for (int g = 0; g < GROUP_SLOTS; g++)
            group_ready[g] = (g < P_GROUP_COUNT);
        source_limit = SOURCE_COUNT_RST;
        usage_limit  = USAGE_COUNT_RST;
    endfunction

    function automatic logic [3:0] handle_status(input logic [15:0] idx,
                                                 input logic [15:0] gen,
                                                 input bit need_loaded);
        if (idx >= P_POOL_SIZE)
            return ST_INDEX;
        if (gen != slot_gen[idx])
            return ST_STALE;
        if (need_loaded && !slot_loaded[idx])
            return ST_NOT_LOADED;
        return ST_OK;
    endfunction

    function automatic logic [3:0] group_status(input logic [7:0] grp);
        if (grp >= P_GROUP_COUNT || grp >= GROUP_SLOTS)
            return ST_GROUP_RANGE;
        if (!group_ready[grp])
            return ST_GROUP_UNINIT;
        return ST_OK;
    endfunction

    // Applies one request to the tracker; returns 0 when no response follows.
    function automatic bit apply_pool_request(input t_req r, output t_rsp rsp);
        logic [3:0]  st;
        logic [7:0]  oi;
        logic [15:0] og;
        logic        rl;
        logic [7:0]  slot;
        int unsigned x;
        st  = ST_OK;
        oi  = '0;
        og  = '0;
        rl  = 1'b0;
        rsp = '0;
        x   = r.handle_index;
        case (r.req_type)
            REQ_ALLOC: begin
                if (free_depth == 0) begin
                    st = ST_EXHAUSTED;
                    og = NO_GEN;
                end else begin
                    free_depth--;
                    slot = free_slots[free_depth];
                    oi   = slot;
                    og   = slot_gen[slot];
                end
            end
            REQ_LOAD: begin
                st = group_status(r.group_id);
                if (st == ST_OK && r.source_id >= source_limit)
                    st = ST_SOURCE;
                if (st == ST_OK && r.usage_kind >= usage_limit)
                    st = ST_USAGE;
                if (st == ST_OK)
                    st = handle_status(r.handle_index, r.handle_gen, 1'b0);
                if (st == ST_OK) begin
                    rl             = slot_loaded[x];
                    slot_loaded[x] = 1'b1;
                    oi             = x[7:0];
                    og             = slot_gen[x];
                end
            end
            REQ_UNLOAD: begin
                st = handle_status(r.handle_index, r.handle_gen, 1'b1);
                if (st == ST_OK) begin
                    slot_loaded[x] = 1'b0;
                    slot_gen[x]    = slot_gen[x] + 16'd1;
                    oi             = x[7:0];
                    og             = slot_gen[x];
                    if (free_depth >= P_POOL_SIZE) begin
                        st = ST_OVERFLOW;
                    end else begin
                        free_slots[free_depth] = x[7:0];
                        free_depth++;
                    end
                end
            end
            REQ_USE: begin
                st = handle_status(r.handle_index, r.handle_gen, 1'b1);
                if (st == ST_OK) begin
                    oi = x[7:0];
                    og = slot_gen[x];
                end
            end
            REQ_GROUP_INIT: begin
                if (r.group_id >= P_GROUP_COUNT || r.group_id >= GROUP_SLOTS)
                    st = ST_GROUP_RANGE;
                else if (group_ready[r.group_id])
                    st = ST_GROUP_ALREADY;
                else
                    group_ready[r.group_id] = 1'b1;
            end
            REQ_GROUP_USE: begin
                st = group_status(r.group_id);
            end
            default: begin
                return 1'b0;
            end
        endcase
        if (st != ST_OK && st != ST_OVERFLOW && st != ST_EXHAUSTED) begin
            oi = '0;
            og = '0;
            rl = 1'b0;
        end
        if (st == ST_OVERFLOW) begin
            oi = '0;
            og = '0;
        end
        rsp.status       = st;
        rsp.out_index    = oi;
        rsp.out_gen      = og;
        rsp.was_reloaded = rl;
        return 1'b1;
    endfunction

    task automatic send_request(input t_req r);
        int unsigned gap;
        t_rsp        rsp;
        int          hits [$];
        gap = steady_flow ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (apply_pool_request(r, rsp)) begin
            awaited_rsp.push_back(rsp);
            if (r.req_type == REQ_ALLOC && rsp.status == ST_OK)
                live_slots.push_back(rsp.out_index);
            if (r.req_type == REQ_UNLOAD &&
                (rsp.status == ST_OK || rsp.status == ST_OVERFLOW)) begin
                hits = live_slots.find_first_index(s) with (s == r.handle_index[7:0]);
                if (hits.size() > 0)
                    live_slots.delete(hits[0]);
            end
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (awaited_rsp.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_SOURCE_COUNT)
            source_limit = val;
        else
            usage_limit = val[3:0];
        @(posedge i_clk);
    endtask

    function automatic t_req random_request();
        t_req        r;
        logic [15:0] idx;
        int unsigned roll;
        int unsigned flaw;
        if (live_slots.size() > 0 && $urandom_range(0, 9) != 0)
            idx = 16'(live_slots[$urandom_range(0, live_slots.size() - 1)]);
        else
            idx = 16'($urandom_range(0, P_POOL_SIZE - 1));
        r = make_request(REQ_LOAD, idx, slot_gen[idx],
                         8'($urandom_range(0, source_limit - 1)),
                         8'($urandom_range(0, P_GROUP_COUNT - 1)),
                         4'($urandom_range(0, usage_limit - 1)));
        roll = $urandom_range(0, 99);
        flaw = $urandom_range(0, 11);
        if (roll < 20) begin
            r.req_type = REQ_ALLOC;
        end else if (roll < 78) begin
            if (roll < 45)
                r.req_type = REQ_LOAD;
            else if (roll < 63)
                r.req_type = REQ_UNLOAD;
            else
                r.req_type = REQ_USE;
            case (flaw)
                0: r.handle_gen = slot_gen[idx] - 16'd1;
                1: r.source_id  = 8'($urandom_range(0, 255));
                2: r.usage_kind = 4'($urandom_range(0, 15));
                3: r.group_id   = 8'($urandom_range(0, 255));
                default: ;
            endcase
        end else if (roll < 86) begin
            r.req_type = ($urandom_range(0, 1) == 0) ? REQ_GROUP_INIT : REQ_GROUP_USE;
            r.group_id = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, GROUP_SLOTS + 1))
                                                     : 8'($urandom_range(0, 255));
        end else begin
            r = make_request(REQ_LOAD, 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             4'($urandom_range(0, 15)));
            if (roll < 96)
                r.req_type = 3'($urandom_range(REQ_LOAD, REQ_USE));
            else
                r.req_type = 3'($urandom_range(6, 7));
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid) begin
            if (awaited_rsp.size() == 0) begin
                stray_count++;
                if (report_count < MAX_REPORTS) begin
                    report_count++;
                    $display("%0t: response with nothing outstanding: st=%0d idx=%0d gen=%h rl=%b",
                             $realtime, o_rsp.status, o_rsp.out_index, o_rsp.out_gen,
                             o_rsp.was_reloaded);
                end
            end else begin
                want = awaited_rsp.pop_front();
                if (o_rsp.status !== want.status || o_rsp.out_index !== want.out_index ||
                    o_rsp.out_gen !== want.out_gen ||
                    o_rsp.was_reloaded !== want.was_reloaded) begin
                    mismatch_count++;
                    if (report_count < MAX_REPORTS) begin
                        report_count++;
                        $display("%0t: mismatch exp st=%0d idx=%0d gen=%h rl=%b",
                                 $realtime, want.status, want.out_index, want.out_gen,
                                 want.was_reloaded);
                        $display("%0t:          got st=%0d idx=%0d gen=%h rl=%b",
                                 $realtime, o_rsp.status, o_rsp.out_index, o_rsp.out_gen,
                                 o_rsp.was_reloaded);
                    end
                end
            end
        end
    end

    // Stack is full after reset: unload of a loaded slot must flag overflow.
    task automatic test_stack_overflow();
        send_request(make_request(REQ_LOAD, 16'd3, 16'd0, 8'd1, 8'd2, 4'd2));
        send_request(make_request(REQ_UNLOAD, 16'd3, 16'd0, 8'd0, 8'd0, 4'd0));
        send_request(make_request(REQ_USE, 16'd3, 16'd0, 8'd0, 8'd0, 4'd0));
    endtask

    task automatic test_handle_lifecycle();
        send_request(make_request(REQ_ALLOC, 16'd0, 16'd0, 8'd0, 8'd0, 4'd0));
        send_request(make_request(REQ_LOAD, 16'd255, 16'd0, 8'd0, 8'd0, 4'd0));
        send_request(make_request(REQ_LOAD, 16'd255, 16'd0, 8'd1, 8'd4, 4'd2));
        send_request(make_request(REQ_USE, 16'd255, 16'd0, 8'd0, 8'd0, 4'd0));
        send_request(make_request(REQ_UNLOAD, 16'd255, 16'd0, 8'd0, 8'd0, 4'd0));
        send_request(make_request(REQ_USE, 16'd255, 16'd0, 8'd0, 8'd0, 4'd0));
        send_request(make_request(REQ_UNLOAD, 16'd255, 16'd0, 8'd0, 8'd0, 4'd0));
    endtask

    task automatic test_error_checks();
        send_request(make_request(REQ_LOAD, 16'hFFFF, 16'd0, 8'd0, 8'd0, 4'd0));
        send_request(make_request(REQ_USE, 16'd256, 16'd0, 8'd0, 8'd0, 4'd0));
        send_request(make_request(REQ_LOAD, 16'd7, 16'd0, 8'd0, 8'd5, 4'd0));
        send_request(make_request(REQ_LOAD, 16'd7, 16'd0, 8'd0, 8'hFF, 4'd0));
        send_request(make_request(REQ_LOAD, 16'd7, 16'd0, 8'd2, 8'd0, 4'd0));
        send_request(make_request(REQ_LOAD, 16'd7, 16'd0, 8'hFF, 8'd1, 4'd0));
        send_request(make_request(REQ_LOAD, 16'd7, 16'd0, 8'd0, 8'd1, 4'd3));
        send_request(make_request(REQ_LOAD, 16'd7, 16'd0, 8'd1, 8'd3, 4'hF));
        send_request(make_request(REQ_UNLOAD, 16'd10, 16'd0, 8'd0, 8'd0, 4'd0));
        send_request(make_request(REQ_USE, 16'd0, 16'hFFFF, 8'hFF, 8'hFF, 4'hF));
        send_request(make_request(REQ_USE, 16'd0, 16'd0, 8'd0, 8'd0, 4'd0));
    endtask

    task automatic test_group_requests();
        send_request(make_request(REQ_GROUP_INIT, 16'd0, 16'd0, 8'd0, 8'd0, 4'd0));
        send_request(make_request(REQ_GROUP_INIT, 16'd0, 16'd0, 8'd0, 8'd7, 4'd0));
        send_request(make_request(REQ_GROUP_INIT, 16'd0, 16'd0, 8'd0, 8'hFF, 4'd0));
        send_request(make_request(REQ_GROUP_USE, 16'd0, 16'd0, 8'd0, 8'd4, 4'd0));
        send_request(make_request(REQ_GROUP_USE, 16'd0, 16'd0, 8'd0, 8'd5, 4'd0));
        send_request(make_request(3'd6, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 4'hF));
        send_request(make_request(3'd7, 16'd1, 16'd0, 8'd0, 8'd0, 4'd0));
    endtask

    task automatic test_pool_exhaustion();
        while (free_depth > 0)
            send_request(make_request(REQ_ALLOC, 16'($urandom_range(0, 65535)), 16'd0,
                                      8'd0, 8'd0, 4'd0));
        repeat (2) send_request(make_request(REQ_ALLOC, 16'd0, 16'd0, 8'd0, 8'd0, 4'd0));
    endtask

    task automatic test_random_traffic(input logic [7:0] sources, input logic [3:0] usages);
        int unsigned sent;
        t_req        r;
        sent = 0;
        wait_idle();
        write_config(CFG_SOURCE_COUNT, sources);
        write_config(CFG_USAGE_COUNT, {4'd0, usages});
        while (sent < PHASE_ITEMS) begin
            if (sent % 40 == 0)
                steady_flow = ($urandom_range(0, 3) == 0);
            r = random_request();
            send_request(r);
            if (r.req_type <= REQ_GROUP_USE)
                sent++;
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        reset_pool_tracker();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_stack_overflow();
        test_handle_lifecycle();
        test_error_checks();
        test_group_requests();
        test_pool_exhaustion();
        test_random_traffic(8'd1, 4'd1);
        test_random_traffic(8'd255, 4'd15);
        test_random_traffic(8'($urandom_range(1, 255)), 4'($urandom_range(1, 15)));
        test_random_traffic(SOURCE_COUNT_RST, USAGE_COUNT_RST);

        wait_idle();
        if (mismatch_count == 0 && stray_count == 0 && awaited_rsp.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
